// File: hw/rtl/hsd_pkg.sv
// Shared constants and types of the Huffman stream decoder.
// Used by the node store and by the top level; depends on nothing else.
`default_nettype none

package hsd_pkg;

    localparam int MAX_NODES = 512;
    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    localparam logic [1:0] PH_SYMBOL = 2'd0;
    localparam logic [1:0] PH_CODE = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [7:0] TERMINATOR = 8'hFF;
    localparam logic [7:0] LIST_END = 8'h00;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    localparam logic [1:0] ST_ACCEPT = 2'd0;
    localparam logic [1:0] ST_HDR_EVAL = 2'd1;
    localparam logic [1:0] ST_DECODE = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
    } link_row_t;

    typedef struct packed {
        logic              rd_en;
        logic [NODE_W-1:0] rd_addr;
        logic              link_we;
        logic              leaf_we;
        logic [NODE_W-1:0] wr_addr;
        link_row_t         link_wdata;
        logic [7:0]        leaf_wdata;
    } store_req_t;

    typedef struct packed {
        logic       busy;
        link_row_t  link_rd;
        logic [7:0] leaf_rd;
    } store_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/hsd_node_store.sv
// Node store of the code trie: link memory, leaf symbol memory and the clearing pass.
// Depends on hsd_pkg.
`default_nettype none

module hsd_node_store
    import hsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire store_req_t req,
    output store_rsp_t      rsp
);

    link_row_t         link_mem [MAX_NODES];
    logic [7:0]        leaf_mem [MAX_NODES];
    link_row_t         link_rd_reg;
    logic [7:0]        leaf_rd_reg;
    logic              clearing_reg;
    logic [NODE_W-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_idx_reg == NODE_W'(MAX_NODES - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            link_mem[clr_idx_reg] <= '0;
        end
        else if (req.link_we)
        begin
            link_mem[req.wr_addr] <= req.link_wdata;
        end
        if (req.rd_en)
        begin
            link_rd_reg <= link_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.leaf_we)
        begin
            leaf_mem[req.wr_addr] <= req.leaf_wdata;
        end
        if (req.rd_en)
        begin
            leaf_rd_reg <= leaf_mem[req.rd_addr];
        end
    end

    assign rsp.busy = clearing_reg;
    assign rsp.link_rd = link_rd_reg;
    assign rsp.leaf_rd = leaf_rd_reg;

endmodule

`default_nettype wire

// File: hw/rtl/huffman_stream_decoder_unit.sv
// Top level of the Huffman stream decoder: header parser, trie builder and bit-serial decoder.
// Depends on hsd_pkg and hsd_node_store.
//
// After reset the node store runs a clearing pass over its link memory, during which no item is
// taken. A header item is handled on acceptance; a code character needs a node read, then a link
// update. A body item is accepted and then decoded bit by bit, each tree step reading the node
// memory; a decoded symbol adds a step, as does a byte that ends on an inner node, and a closing
// step ends the item. Decoding waits while a pending result cannot move on. The final item decodes
// only the valid bits of the last byte. Each result item leaves through an output register, and
// the last result of an input item carries tlast.
`default_nettype none

module huffman_stream_decoder_unit
    import hsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // file_byte[7:0]
    input  wire logic       s_tlast,   // final_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // symbol[7:0]
    output logic            m_tuser,   // status
    output logic            m_tlast    // run_last
);

    store_req_t req;
    store_rsp_t rsp;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        entry_symbol_reg, entry_symbol_next;
    logic [NODE_W-1:0] walk_node_reg, walk_node_next;
    logic [CNT_W-1:0]  nodes_used_reg, nodes_used_next;
    link_row_t         root_row_reg, root_row_next;
    logic [7:0]        delay_newer_reg, delay_newer_next;
    logic              have_byte_reg, have_byte_next;
    logic [7:0]        shift_reg, shift_next;
    logic [3:0]        bits_left_reg, bits_left_next;
    logic              chk_reg, chk_next;
    logic              use_root_reg, use_root_next;
    logic              char_zero_reg, char_zero_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_symbol_reg, pend_symbol_next;
    logic              pend_status_reg, pend_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_symbol_reg, out_symbol_next;
    logic              out_status_reg, out_status_next;
    logic              out_last_reg, out_last_next;

    hsd_node_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    assign s_tready = (state_reg == ST_ACCEPT) && !rsp.busy;
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_symbol_reg;
    assign m_tuser = out_status_reg;
    assign m_tlast = out_last_reg;

    always_comb
    begin
        link_row_t         row;
        link_row_t         new_row;
        logic [NODE_W-1:0] nxt;
        logic [NODE_W-1:0] link;
        logic              out_free;
        logic              step_ok;
        logic              bit_go;
        logic              gen;
        logic [7:0]        gen_symbol;
        logic              gen_status;
        logic              finish;
        logic [3:0]        fin_cnt;

        state_next = state_reg;
        phase_next = phase_reg;
        entry_symbol_next = entry_symbol_reg;
        walk_node_next = walk_node_reg;
        nodes_used_next = nodes_used_reg;
        root_row_next = root_row_reg;
        delay_newer_next = delay_newer_reg;
        have_byte_next = have_byte_reg;
        shift_next = shift_reg;
        bits_left_next = bits_left_reg;
        chk_next = chk_reg;
        use_root_next = use_root_reg;
        char_zero_next = char_zero_reg;
        pend_valid_next = pend_valid_reg;
        pend_symbol_next = pend_symbol_reg;
        pend_status_next = pend_status_reg;
        out_symbol_next = out_symbol_reg;
        out_status_next = out_status_reg;
        out_last_next = out_last_reg;
        out_valid_next = out_valid_reg && !m_tready;

        req = '0;
        req.wr_addr = walk_node_reg;
        req.leaf_wdata = entry_symbol_reg;

        out_free = !out_valid_reg || m_tready;
        step_ok = !pend_valid_reg || out_free;
        row = (chk_reg || !use_root_reg) ? rsp.link_rd : root_row_reg;
        nxt = shift_reg[7] ? row.right : row.left;
        link = char_zero_reg ? rsp.link_rd.left : rsp.link_rd.right;
        new_row = rsp.link_rd;
        if (char_zero_reg)
        begin
            new_row.left = nodes_used_reg[NODE_W-1:0];
        end
        else
        begin
            new_row.right = nodes_used_reg[NODE_W-1:0];
        end
        fin_cnt = (s_tdata > 8'd8) ? 4'd8 : s_tdata[3:0];
        bit_go = 1'b0;
        gen = 1'b0;
        gen_symbol = 8'h00;
        gen_status = 1'b0;
        finish = 1'b0;

        unique case (state_reg)
            ST_ACCEPT:
            begin
                if (s_tvalid && s_tready)
                begin
                    priority if (phase_reg == PH_DONE)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (s_tlast)
                    begin
                        phase_next = PH_DONE;
                        if (phase_reg == PH_BODY && have_byte_reg)
                        begin
                            shift_next = 8'(delay_newer_reg << (4'd8 - fin_cnt));
                            bits_left_next = fin_cnt;
                            state_next = ST_DECODE;
                        end
                    end
                    else if (phase_reg == PH_SYMBOL)
                    begin
                        walk_node_next = '0;
                        if (s_tdata == LIST_END)
                        begin
                            phase_next = PH_BODY;
                            use_root_next = 1'b1;
                        end
                        else
                        begin
                            entry_symbol_next = s_tdata;
                            phase_next = PH_CODE;
                        end
                    end
                    else if (phase_reg == PH_CODE)
                    begin
                        if (s_tdata == TERMINATOR)
                        begin
                            req.leaf_we = 1'b1;
                            walk_node_next = '0;
                            phase_next = PH_SYMBOL;
                        end
                        else
                        begin
                            req.rd_en = 1'b1;
                            req.rd_addr = walk_node_reg;
                            char_zero_next = (s_tdata == CHAR_ZERO);
                            state_next = ST_HDR_EVAL;
                        end
                    end
                    else
                    begin
                        delay_newer_next = s_tdata;
                        have_byte_next = 1'b1;
                        if (have_byte_reg)
                        begin
                            shift_next = delay_newer_reg;
                            bits_left_next = 4'd8;
                            state_next = ST_DECODE;
                        end
                    end
                end
            end
            ST_HDR_EVAL:
            begin
                state_next = ST_ACCEPT;
                if (link != '0)
                begin
                    walk_node_next = link;
                end
                else if (nodes_used_reg < CNT_W'(MAX_NODES))
                begin
                    req.link_we = 1'b1;
                    req.link_wdata = new_row;
                    if (walk_node_reg == '0)
                    begin
                        root_row_next = new_row;
                    end
                    walk_node_next = nodes_used_reg[NODE_W-1:0];
                    nodes_used_next = nodes_used_reg + 1'b1;
                end
            end
            ST_DECODE:
            begin
                if (step_ok)
                begin
                    priority if (chk_reg)
                    begin
                        chk_next = 1'b0;
                        if (rsp.link_rd.left == '0 && rsp.link_rd.right == '0)
                        begin
                            gen = 1'b1;
                            gen_symbol = rsp.leaf_rd;
                            use_root_next = 1'b1;
                        end
                        else
                        begin
                            use_root_next = 1'b0;
                            bit_go = (bits_left_reg != 4'd0);
                        end
                    end
                    else if (bits_left_reg != 4'd0)
                    begin
                        bit_go = 1'b1;
                    end
                    else
                    begin
                        finish = 1'b1;
                        state_next = ST_ACCEPT;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACCEPT;
            end
        endcase

        if (bit_go)
        begin
            shift_next = {shift_reg[6:0], 1'b0};
            bits_left_next = bits_left_reg - 4'd1;
            if (nxt == '0)
            begin
                gen = 1'b1;
                gen_status = 1'b1;
                use_root_next = 1'b1;
            end
            else
            begin
                req.rd_en = 1'b1;
                req.rd_addr = nxt;
                chk_next = 1'b1;
            end
        end

        if (gen)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_symbol_next = pend_symbol_reg;
                out_status_next = pend_status_reg;
                out_last_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_symbol_next = gen_symbol;
            pend_status_next = gen_status;
        end

        if (finish && pend_valid_reg)
        begin
            out_valid_next = 1'b1;
            out_symbol_next = pend_symbol_reg;
            out_status_next = pend_status_reg;
            out_last_next = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCEPT;
            phase_reg <= PH_SYMBOL;
            entry_symbol_reg <= '0;
            walk_node_reg <= '0;
            nodes_used_reg <= CNT_W'(1);
            root_row_reg <= '0;
            delay_newer_reg <= '0;
            have_byte_reg <= 1'b0;
            shift_reg <= '0;
            bits_left_reg <= '0;
            chk_reg <= 1'b0;
            use_root_reg <= 1'b1;
            char_zero_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_symbol_reg <= '0;
            pend_status_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_symbol_reg <= '0;
            out_status_reg <= 1'b0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            entry_symbol_reg <= entry_symbol_next;
            walk_node_reg <= walk_node_next;
            nodes_used_reg <= nodes_used_next;
            root_row_reg <= root_row_next;
            delay_newer_reg <= delay_newer_next;
            have_byte_reg <= have_byte_next;
            shift_reg <= shift_next;
            bits_left_reg <= bits_left_next;
            chk_reg <= chk_next;
            use_root_reg <= use_root_next;
            char_zero_reg <= char_zero_next;
            pend_valid_reg <= pend_valid_next;
            pend_symbol_reg <= pend_symbol_next;
            pend_status_reg <= pend_status_next;
            out_valid_reg <= out_valid_next;
            out_symbol_reg <= out_symbol_next;
            out_status_reg <= out_status_next;
            out_last_reg <= out_last_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        nodes_used_reg != '0 && nodes_used_reg <= CNT_W'(MAX_NODES))
        else $error("Node count left its range.");

    assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'(walk_node_reg) < nodes_used_reg)
        else $error("Walk points at a node that was never allocated.");

    assert property (@(posedge clk) disable iff (!rst_n)
        chk_reg |-> state_reg == ST_DECODE)
        else $error("Leaf check pending outside of decoding.");

    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("Stream left the done phase without reset.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.busy |-> !s_tready)
        else $error("Item taken during the clearing pass.");

endmodule

`default_nettype wire

// File: sim/tb_huffman_stream_decoder_unit.sv
// Self-checking testbench for huffman_stream_decoder_unit: builds a code trie through the header,
// decodes a body made of random trie walks and compares every result with its own predictor.
// Depends on hsd_pkg and the RTL of the decoder.
`timescale 1ns / 1ps

module tb_huffman_stream_decoder_unit;

    import hsd_pkg::*;

    localparam int BODY_BYTES = 340;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } file_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       status;
        logic       run_last;
    } sym_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tuser;
    logic       m_tlast;

    // Decoder state as the predictor sees it.
    logic [1:0]        parse_ph;
    logic [7:0]        entry_sym;
    logic [NODE_W-1:0] walk_at;
    int                nodes_in_use;
    logic [NODE_W-1:0] zero_child [MAX_NODES];
    logic [NODE_W-1:0] one_child [MAX_NODES];
    logic [7:0]        leaf_sym [MAX_NODES];
    logic [7:0]        body_older;
    logic [7:0]        body_newer;
    int                body_held;
    sym_result_t       step_results[$];
    sym_result_t       symbol_expect_q[$];
    int                symbols_pending = 0;

    file_item_t        file_q[$];
    int                n_pushed = 0;
    int                n_accepted = 0;
    int                n_symbols = 0;
    int                n_absent = 0;
    int                mismatch_count = 0;
    int                idle_run = 0;
    logic              in_taken = 1'b0;
    logic              out_taken = 1'b0;

    int                tx_gap = 0;
    logic              tx_steady = 1'b0;
    int                rx_gap = 0;
    logic              rx_steady = 1'b0;
    int                hold_cycles = 0;
    logic              hold_arm = 1'b0;
    logic              hold_spent = 1'b0;
    wire               rx_hold = (hold_cycles != 0);

    // Walk of the stimulus generator through the finished trie.
    logic [NODE_W-1:0] gen_node = '0;
    int                gen_depth = 0;

    huffman_stream_decoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic void trace_bits(input logic [7:0] b, input int nbits);
        logic [NODE_W-1:0] nxt;
        sym_result_t       r;
        for (int i = nbits - 1; i >= 0; i--)
        begin
            nxt = b[i] ? one_child[walk_at] : zero_child[walk_at];
            r.run_last = 1'b0;
            if (nxt == '0)
            begin
                r.symbol = 8'h00;
                r.status = 1'b1;
                step_results.insert(step_results.size(), r);
                walk_at = '0;
            end
            else if (zero_child[nxt] == '0 && one_child[nxt] == '0)
            begin
                r.symbol = leaf_sym[nxt];
                r.status = 1'b0;
                step_results.insert(step_results.size(), r);
                walk_at = '0;
            end
            else
            begin
                walk_at = nxt;
            end
        end
    endfunction

    function automatic void decode_file_byte(input logic [7:0] b, input logic fin);
        logic [NODE_W-1:0] nxt;
        logic              go_zero;
        step_results.delete();
        if (parse_ph != PH_DONE)
        begin
            if (fin)
            begin
                if (parse_ph == PH_BODY && body_held > 0)
                    trace_bits(body_newer, (b > 8'd8) ? 8 : int'(b));
                parse_ph = PH_DONE;
            end
            else if (parse_ph == PH_SYMBOL)
            begin
                walk_at = '0;
                if (b == LIST_END)
                    parse_ph = PH_BODY;
                else
                begin
                    entry_sym = b;
                    parse_ph = PH_CODE;
                end
            end
            else if (parse_ph == PH_CODE)
            begin
                if (b == TERMINATOR)
                begin
                    leaf_sym[walk_at] = entry_sym;
                    walk_at = '0;
                    parse_ph = PH_SYMBOL;
                end
                else
                begin
                    go_zero = (b == CHAR_ZERO);
                    nxt = go_zero ? zero_child[walk_at] : one_child[walk_at];
                    if (nxt != '0)
                        walk_at = nxt;
                    else if (nodes_in_use < MAX_NODES)
                    begin
                        nxt = NODE_W'(nodes_in_use);
                        if (go_zero)
                            zero_child[walk_at] = nxt;
                        else
                            one_child[walk_at] = nxt;
                        nodes_in_use++;
                        walk_at = nxt;
                    end
                end
            end
            else
            begin
                body_older = body_newer;
                body_newer = b;
                if (body_held > 0)
                    trace_bits(body_older, 8);
                if (body_held < 2)
                    body_held++;
            end
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].run_last = 1'b1;
        foreach (step_results[i])
        begin
            symbol_expect_q.insert(symbol_expect_q.size(), step_results[i]);
            symbols_pending++;
        end
    endfunction

    function automatic void push_item(input logic [7:0] data, input logic fin);
        file_item_t it;
        it.data = data;
        it.fin = fin;
        file_q.insert(file_q.size(), it);
        n_pushed++;
    endfunction

    // Any byte other than the zero character and the terminator steps to the one child.
    function automatic logic [7:0] code_char(input logic one);
        logic [7:0] c;
        c = CHAR_ZERO;
        if (one)
        begin
            c = 8'($urandom_range(0, 253));
            if (c >= CHAR_ZERO)
                c = c + 8'd1;
        end
        return c;
    endfunction

    function automatic void push_entry(input logic [7:0] sym, input logic [15:0] code,
                                       input int len, input int extra);
        push_item(sym, 1'b0);
        for (int j = len - 1; j >= 0; j--)
            push_item(code_char(code[j]), 1'b0);
        for (int j = 0; j < extra; j++)
            push_item(code_char(1'($urandom_range(0, 1))), 1'b0);
        push_item(TERMINATOR, 1'b0);
    endfunction

    function automatic void advance_walk(input logic b);
        logic [NODE_W-1:0] nxt;
        nxt = b ? one_child[gen_node] : zero_child[gen_node];
        if (nxt == '0 || (zero_child[nxt] == '0 && one_child[nxt] == '0))
        begin
            gen_node = '0;
            gen_depth = 0;
        end
        else
        begin
            gen_node = nxt;
            gen_depth++;
        end
    endfunction

    // Mostly follows existing branches; deep single-child paths end on the absent side.
    function automatic logic next_walk_bit();
        logic has0;
        logic has1;
        logic b;
        has0 = (zero_child[gen_node] != '0);
        has1 = (one_child[gen_node] != '0);
        if ($urandom_range(0, 99) < 5 || has0 == has1)
            b = 1'($urandom_range(0, 1));
        else if (gen_depth > 16)
            b = has0;
        else
            b = has1;
        advance_walk(b);
        return b;
    endfunction

    always @(negedge clk)
    begin
        file_item_t item;
        logic       offer;
        offer = s_tvalid;
        if (s_tvalid && in_taken)
        begin
            offer = 1'b0;
            if ($urandom_range(0, 39) == 0)
                tx_steady = !tx_steady;
            tx_gap = tx_steady ? 0 : $urandom_range(0, 19);
        end
        if (rst_n && !offer)
        begin
            if (tx_gap > 0)
                tx_gap--;
            else if (file_q.size() > 0)
            begin
                item = file_q.pop_front();
                s_tdata <= item.data;
                s_tlast <= item.fin;
                offer = 1'b1;
            end
        end
        s_tvalid <= offer;
    end

    always @(negedge clk)
    begin
        if (out_taken)
        begin
            if ($urandom_range(0, 39) == 0)
                rx_steady = !rx_steady;
            rx_gap = rx_steady ? 0 : $urandom_range(0, 19);
        end
        else if (rx_gap > 0)
            rx_gap--;
        m_tready <= rst_n && !rx_hold && (rx_gap == 0);
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
        else if (hold_arm && !hold_spent)
        begin
            hold_cycles <= HOLD_CYCLES;
            hold_spent <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        sym_result_t want;
        in_taken = s_tvalid && s_tready;
        out_taken = m_tvalid && m_tready;
        if (in_taken)
        begin
            decode_file_byte(s_tdata, s_tlast);
            n_accepted++;
        end
        if (out_taken)
        begin
            if (symbol_expect_q.size() == 0)
                report_mismatch($sformatf("result symbol=%02h status=%0b last=%0b not expected",
                                          m_tdata, m_tuser, m_tlast));
            else
            begin
                want = symbol_expect_q.pop_front();
                symbols_pending--;
                if (m_tdata !== want.symbol)
                    report_mismatch($sformatf("symbol %02h, expected %02h",
                                              m_tdata, want.symbol));
                if (m_tuser !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b",
                                              m_tuser, want.status));
                if (m_tlast !== want.run_last)
                    report_mismatch($sformatf("run_last %0b, expected %0b",
                                              m_tlast, want.run_last));
                if (want.status)
                    n_absent++;
                else
                    n_symbols++;
            end
        end
        if (in_taken || out_taken)
            idle_run = 0;
        else
            idle_run++;
        if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] Watchdog: no item moved for %0d cycles", $time, idle_run);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] code_val [16];
        int          code_len [16];
        int          n_leaves;
        int          n_codes;
        int          pick;
        int          chain_len;
        int          header_items;
        int          prefix_at;
        logic [7:0]  sym;
        logic [7:0]  body_byte;
        logic [7:0]  final_cnt;

        parse_ph = PH_SYMBOL;
        entry_sym = 8'h00;
        walk_at = '0;
        nodes_in_use = 1;
        body_older = 8'h00;
        body_newer = 8'h00;
        body_held = 0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            zero_child[i] = '0;
            one_child[i] = '0;
            leaf_sym[i] = 8'h00;
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A complete prefix code: every internal node has both children.
        n_leaves = $urandom_range(6, 16);
        code_val[0] = 16'h0;
        code_len[0] = 0;
        n_codes = 1;
        while (n_codes < n_leaves)
        begin
            pick = $urandom_range(0, n_codes - 1);
            if (code_len[pick] < 10)
            begin
                code_val[n_codes] = (code_val[pick] << 1) | 16'h1;
                code_len[n_codes] = code_len[pick] + 1;
                code_val[pick] = code_val[pick] << 1;
                code_len[pick]++;
                n_codes++;
            end
        end
        for (int k = 0; k < n_leaves; k++)
        begin
            sym = 8'($urandom_range(2, 254));
            if (k == 2)
                sym = 8'hFF;
            else if (k == 3)
                sym = 8'h01;
            push_entry(sym, code_val[k], code_len[k], 0);
        end

        // Empty code, a re-terminated leaf and a code that ends on an inner node.
        push_entry(8'h5A, 16'h0, 0, 0);
        push_entry(8'($urandom_range(1, 255)), code_val[4], code_len[4], 0);
        prefix_at = 0;
        for (int k = n_leaves - 1; k >= 0; k--)
            if (code_len[k] >= 2)
                prefix_at = k;
        push_entry(8'h7E, code_val[prefix_at] >> 1, code_len[prefix_at] - 1, 0);

        // A long chain of single-child nodes grows below one leaf and turns it into an inner node.
        chain_len = 24;
        push_entry(8'($urandom_range(1, 255)), code_val[0], code_len[0], chain_len);
        push_entry(8'h80, code_val[1], code_len[1], 1);
        push_item(LIST_END, 1'b0);
        header_items = n_pushed;

        wait (n_accepted == n_pushed);

        gen_node = '0;
        gen_depth = 0;
        push_item(8'h00, 1'b0);
        push_item(8'hFF, 1'b0);
        for (int j = 0; j < 8; j++)
            advance_walk(1'b0);
        for (int j = 0; j < 8; j++)
            advance_walk(1'b1);
        for (int n = 0; n < BODY_BYTES; n++)
        begin
            for (int j = 7; j >= 0; j--)
                body_byte[j] = next_walk_bit();
            push_item(body_byte, 1'b0);
        end

        case ($urandom_range(0, 3))
            0: final_cnt = 8'd0;
            1: final_cnt = 8'($urandom_range(1, 7));
            2: final_cnt = 8'd8;
            default: final_cnt = 8'($urandom_range(9, 255));
        endcase
        push_item(final_cnt, 1'b1);
        for (int j = 0; j < 5; j++)
            push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

        wait (n_accepted >= header_items + 120);
        hold_arm = 1'b1;

        wait (n_accepted == n_pushed);
        wait (symbols_pending == 0);
        repeat (40) @(posedge clk);

        if (symbol_expect_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", symbol_expect_q.size()));
        $display("Run: %0d header items built %0d trie nodes, then %0d body bytes, count %0d.",
                 header_items, nodes_in_use, BODY_BYTES + 2, final_cnt);
        $display("Checked %0d decoded symbols and %0d absent-node results.",
                 n_symbols, n_absent);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
